// ===== sv/dpl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpl_pkg: shared types and constants for the pad locator
// Register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package dpl_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ORG_W      = 12;
    localparam int ROWS_W     = 4;
    localparam int ROW_IDX_W  = 4;
    localparam int COL_IDX_W  = 8;
    localparam int PAD_W      = 11;
    localparam int SIZE16_W   = 12;

    localparam logic [CFG_ADDR_W-1:0] CFG_COL_ORIGIN  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_ORIGIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS_IN_USE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_HEIGHTS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_WIDTHS  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_COLUMNS = 3'd5;

    localparam logic [ORG_W-1:0]  RST_COL_ORIGIN  = 12'hFA6;
    localparam logic [ORG_W-1:0]  RST_ROW_ORIGIN  = 12'hFE2;
    localparam logic [ROWS_W-1:0] RST_ROWS_IN_USE = 4'd1;

    typedef struct packed {
        logic [ORG_W-1:0]      col_org;
        logic [ORG_W-1:0]      row_org;
        logic [ROWS_W-1:0]     rows;
        logic [CFG_DATA_W-1:0] heights;
        logic [CFG_DATA_W-1:0] widths;
        logic [CFG_DATA_W-1:0] columns;
    } t_cfg;

endpackage

// ===== sv/dpl_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpl_cfg: configuration register file
// Holds the origins, active row count and packed per-row geometry.
// ----------------------------------------------------------------------------
module dpl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [dpl_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dpl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output dpl_pkg::t_cfg                  o_cfg
);

    dpl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.col_org <= dpl_pkg::RST_COL_ORIGIN;
            r_cfg.row_org <= dpl_pkg::RST_ROW_ORIGIN;
            r_cfg.rows    <= dpl_pkg::RST_ROWS_IN_USE;
            r_cfg.heights <= '0;
            r_cfg.widths  <= '0;
            r_cfg.columns <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                dpl_pkg::CFG_COL_ORIGIN:  r_cfg.col_org <= i_cfg_wdata[dpl_pkg::ORG_W-1:0];
                dpl_pkg::CFG_ROW_ORIGIN:  r_cfg.row_org <= i_cfg_wdata[dpl_pkg::ORG_W-1:0];
                dpl_pkg::CFG_ROWS_IN_USE: r_cfg.rows    <= i_cfg_wdata[dpl_pkg::ROWS_W-1:0];
                dpl_pkg::CFG_ROW_HEIGHTS: r_cfg.heights <= i_cfg_wdata;
                dpl_pkg::CFG_ROW_WIDTHS:  r_cfg.widths  <= i_cfg_wdata;
                dpl_pkg::CFG_ROW_COLUMNS: r_cfg.columns <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/dpl_sub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpl_sub: shared shift-and-subtract unit
// Computes a - (b << sh) for the origin offsets, the row walk and the column division.
// ----------------------------------------------------------------------------
module dpl_sub #(
    parameter int W = 22
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [3:0]   i_sh,
    output logic [W-1:0] o_diff
);

    logic [W-1:0] b_sh;

    assign b_sh   = i_b << i_sh;
    assign o_diff = i_a - b_sh;

endmodule

// ===== sv/dpl_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpl_seq: pad search sequencer
// Walks the rows one per cycle, then divides out the column bit by bit.
// ----------------------------------------------------------------------------
module dpl_seq #(
    parameter int MAX_ROWS = 8,
    parameter int CW       = 16,
    parameter int W        = 22
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  dpl_pkg::t_cfg                 i_cfg,
    input  logic signed [CW-1:0]          i_pos_row_axis,
    input  logic signed [CW-1:0]          i_pos_col_axis,
    input  logic [W-1:0]                  i_diff,
    output logic [W-1:0]                  o_op_a,
    output logic [W-1:0]                  o_op_b,
    output logic [3:0]                    o_op_sh,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic                          o_hit_found,
    output logic [dpl_pkg::ROW_IDX_W-1:0] o_row_index,
    output logic [dpl_pkg::COL_IDX_W-1:0] o_column_index,
    output logic [dpl_pkg::PAD_W-1:0]     o_pad_number
);

    localparam int RW = $clog2(MAX_ROWS + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ROW      = 3'd1;
    localparam logic [2:0] S_COL_INIT = 3'd2;
    localparam logic [2:0] S_COL_OVF  = 3'd3;
    localparam logic [2:0] S_COL_DIV  = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [RW-1:0]                 r_row_i, n_row_i;
    logic [RW-1:0]                 r_nrows, n_nrows;
    logic [W-1:0]                  r_t, n_t;
    logic signed [CW-1:0]          r_pc, n_pc;
    logic [dpl_pkg::PAD_W-1:0]     r_pad_acc, n_pad_acc;
    logic [dpl_pkg::ROW_IDX_W-1:0] r_row, n_row;
    logic [dpl_pkg::SIZE16_W-1:0]  r_w16, n_w16;
    logic [7:0]                    r_ncols, n_ncols;
    logic [7:0]                    r_q, n_q;
    logic [2:0]                    r_k, n_k;
    logic                          r_valid, n_valid;
    logic                          r_hit, n_hit;
    logic [dpl_pkg::ROW_IDX_W-1:0] r_row_o, n_row_o;
    logic [dpl_pkg::COL_IDX_W-1:0] r_col_o, n_col_o;
    logic [dpl_pkg::PAD_W-1:0]     r_pad_o, n_pad_o;

    logic [2:0] row_sel;
    logic [7:0] h_byte;
    logic [7:0] w_byte;
    logic [7:0] c_byte;
    logic       neg;
    logic       t_pos;

    assign row_sel = 3'(r_row_i);
    assign h_byte  = i_cfg.heights[{row_sel, 3'b000} +: 8];
    assign w_byte  = i_cfg.widths[{row_sel, 3'b000} +: 8];
    assign c_byte  = i_cfg.columns[{row_sel, 3'b000} +: 8];
    assign neg     = i_diff[W-1];
    assign t_pos   = !r_t[W-1] && (r_t != '0);

    always_comb begin
        logic [W-1:0] rem_n;
        logic [7:0]   q_n;
        logic [7:0]   col_n;

        n_state   = r_state;
        n_row_i   = r_row_i;
        n_nrows   = r_nrows;
        n_t       = r_t;
        n_pc      = r_pc;
        n_pad_acc = r_pad_acc;
        n_row     = r_row;
        n_w16     = r_w16;
        n_ncols   = r_ncols;
        n_q       = r_q;
        n_k       = r_k;
        n_valid   = 1'b0;
        n_hit     = r_hit;
        n_row_o   = r_row_o;
        n_col_o   = r_col_o;
        n_pad_o   = r_pad_o;
        o_op_a    = r_t;
        o_op_b    = '0;
        o_op_sh   = 4'd0;
        rem_n     = r_t;
        q_n       = r_q;
        col_n     = '0;

        unique case (r_state)
            S_IDLE: begin
                o_op_a = {{(W-CW){i_pos_row_axis[CW-1]}}, i_pos_row_axis};
                o_op_b = {{(W-dpl_pkg::ORG_W-4){i_cfg.row_org[dpl_pkg::ORG_W-1]}},
                          i_cfg.row_org, 4'b0000};
                if (i_start) begin
                    n_t       = i_diff;
                    n_pc      = i_pos_col_axis;
                    n_row_i   = '0;
                    n_pad_acc = '0;
                    n_nrows   = (i_cfg.rows > dpl_pkg::ROWS_W'(MAX_ROWS)) ?
                                RW'(MAX_ROWS) : RW'(i_cfg.rows);
                    n_state   = S_ROW;
                end
            end
            S_ROW: begin
                o_op_a = r_t;
                o_op_b = {{(W-12){1'b0}}, h_byte, 4'b0000};
                if (r_row_i == r_nrows) begin
                    n_valid = 1'b1;
                    n_hit   = 1'b0;
                    n_row_o = '0;
                    n_col_o = '0;
                    n_pad_o = '0;
                    n_state = S_IDLE;
                end else if (t_pos && neg) begin
                    n_row   = dpl_pkg::ROW_IDX_W'(r_row_i) + 1'b1;
                    n_w16   = {w_byte, 4'b0000};
                    n_ncols = c_byte;
                    n_state = S_COL_INIT;
                end else begin
                    n_t       = i_diff;
                    n_pad_acc = r_pad_acc + dpl_pkg::PAD_W'(c_byte);
                    n_row_i   = r_row_i + 1'b1;
                end
            end
            S_COL_INIT: begin
                o_op_a = {{(W-CW){r_pc[CW-1]}}, r_pc};
                o_op_b = {{(W-dpl_pkg::ORG_W-4){i_cfg.col_org[dpl_pkg::ORG_W-1]}},
                          i_cfg.col_org, 4'b0000};
                if (neg || (i_diff == '0)) begin
                    n_valid = 1'b1;
                    n_hit   = 1'b0;
                    n_row_o = r_row;
                    n_col_o = '0;
                    n_pad_o = '0;
                    n_state = S_IDLE;
                end else begin
                    n_t     = i_diff;
                    n_state = S_COL_OVF;
                end
            end
            S_COL_OVF: begin
                o_op_a  = r_t;
                o_op_b  = {{(W-dpl_pkg::SIZE16_W){1'b0}}, r_w16};
                o_op_sh = 4'd8;
                if (!neg) begin
                    n_valid = 1'b1;
                    n_hit   = 1'b0;
                    n_row_o = r_row;
                    n_col_o = '0;
                    n_pad_o = '0;
                    n_state = S_IDLE;
                end else begin
                    n_q     = '0;
                    n_k     = 3'd7;
                    n_state = S_COL_DIV;
                end
            end
            S_COL_DIV: begin
                o_op_a  = r_t;
                o_op_b  = {{(W-dpl_pkg::SIZE16_W){1'b0}}, r_w16};
                o_op_sh = {1'b0, r_k};
                rem_n   = neg ? r_t : i_diff;
                q_n     = r_q;
                q_n[r_k] = !neg;
                col_n   = q_n + 1'b1;
                n_t     = rem_n;
                n_q     = q_n;
                n_k     = r_k - 1'b1;
                if (r_k == 3'd0) begin
                    n_valid = 1'b1;
                    n_row_o = r_row;
                    if ((rem_n != '0) && (q_n < r_ncols)) begin
                        n_hit   = 1'b1;
                        n_col_o = col_n;
                        n_pad_o = r_pad_acc + dpl_pkg::PAD_W'(col_n);
                    end else begin
                        n_hit   = 1'b0;
                        n_col_o = '0;
                        n_pad_o = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_i   <= n_row_i;
        r_nrows   <= n_nrows;
        r_t       <= n_t;
        r_pc      <= n_pc;
        r_pad_acc <= n_pad_acc;
        r_row     <= n_row;
        r_w16     <= n_w16;
        r_ncols   <= n_ncols;
        r_q       <= n_q;
        r_k       <= n_k;
        r_hit     <= n_hit;
        r_row_o   <= n_row_o;
        r_col_o   <= n_col_o;
        r_pad_o   <= n_pad_o;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_hit_found    = r_hit;
    assign o_row_index    = r_row_o;
    assign o_column_index = r_col_o;
    assign o_pad_number   = r_pad_o;

endmodule

// ===== sv/detector_pad_locator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_pad_locator_core: hit position to readout pad lookup
// Rows are walked on the shared subtractor; the column division then does
// one overflow check and eight quotient bits. The next item may start in
// the strobe cycle. The receiver cannot stall; o_valid pulses one cycle.
// Synchronous active-low reset restores register defaults and idles the block.
// ----------------------------------------------------------------------------
module detector_pad_locator_core #(
    parameter int MAX_ROWS    = 8,
    parameter int COORD_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  i_pos_row_axis,
    input  logic signed [COORD_WIDTH-1:0]  i_pos_col_axis,
    input  logic                           i_cfg_wr_en,
    input  logic [dpl_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dpl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                           o_valid,
    output logic                           o_hit_found,
    output logic [dpl_pkg::ROW_IDX_W-1:0]  o_row_index,
    output logic [dpl_pkg::COL_IDX_W-1:0]  o_column_index,
    output logic [dpl_pkg::PAD_W-1:0]      o_pad_number
);

    localparam int SUB_W = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 6;

    dpl_pkg::t_cfg    cfg;
    logic [SUB_W-1:0] op_a;
    logic [SUB_W-1:0] op_b;
    logic [3:0]       op_sh;
    logic [SUB_W-1:0] diff;

    dpl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dpl_sub #(
        .W (SUB_W)
    ) u_sub (
        .i_a    (op_a),
        .i_b    (op_b),
        .i_sh   (op_sh),
        .o_diff (diff)
    );

    dpl_seq #(
        .MAX_ROWS (MAX_ROWS),
        .CW       (COORD_WIDTH),
        .W        (SUB_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_cfg          (cfg),
        .i_pos_row_axis (i_pos_row_axis),
        .i_pos_col_axis (i_pos_col_axis),
        .i_diff         (diff),
        .o_op_a         (op_a),
        .o_op_b         (op_b),
        .o_op_sh        (op_sh),
        .o_busy         (busy),
        .o_valid        (o_valid),
        .o_hit_found    (o_hit_found),
        .o_row_index    (o_row_index),
        .o_column_index (o_column_index),
        .o_pad_number   (o_pad_number)
    );

endmodule

// ===== sim/tb_detector_pad_locator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detector_pad_locator_core: self-checking bench for the pad locator
// Drives hit positions through the start/busy handshake and predicts each pad
// lookup from a local copy of the geometry registers. Directed hits cover
// edges, empty rows and columns, row-count limits and the largest pad number.
// Random phases then reload the geometry and send hits aimed mostly at rows
// and columns, with varying sender idle rates.
// ----------------------------------------------------------------------------
module tb_detector_pad_locator_core;

    localparam int MAX_ROWS     = 8;
    localparam int COORD_WIDTH  = 16;
    localparam int DRAIN_CYCLES = 25;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 24;
    localparam int PHASE_HITS   = 77;

    localparam logic [dpl_pkg::CFG_ADDR_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [dpl_pkg::CFG_ADDR_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int GEO_LOWEST  = 0;
    localparam int GEO_HIGHEST = 1;
    localparam int GEO_RANDOM  = 2;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] row_pos;
        logic [COORD_WIDTH-1:0] col_pos;
    } t_hit_item;

    typedef struct packed {
        logic                          hit;
        logic [dpl_pkg::ROW_IDX_W-1:0] row;
        logic [dpl_pkg::COL_IDX_W-1:0] col;
        logic [dpl_pkg::PAD_W-1:0]     pad;
    } t_pad_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic signed [COORD_WIDTH-1:0]  i_pos_row_axis = '0;
    logic signed [COORD_WIDTH-1:0]  i_pos_col_axis = '0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [dpl_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [dpl_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                           o_valid;
    logic                           o_hit_found;
    logic [dpl_pkg::ROW_IDX_W-1:0]  o_row_index;
    logic [dpl_pkg::COL_IDX_W-1:0]  o_column_index;
    logic [dpl_pkg::PAD_W-1:0]      o_pad_number;

    logic signed [dpl_pkg::ORG_W-1:0] geo_col_org = dpl_pkg::RST_COL_ORIGIN;
    logic signed [dpl_pkg::ORG_W-1:0] geo_row_org = dpl_pkg::RST_ROW_ORIGIN;
    logic [dpl_pkg::ROWS_W-1:0]       geo_rows    = dpl_pkg::RST_ROWS_IN_USE;
    logic [dpl_pkg::CFG_DATA_W-1:0]   geo_heights = '0;
    logic [dpl_pkg::CFG_DATA_W-1:0]   geo_widths  = '0;
    logic [dpl_pkg::CFG_DATA_W-1:0]   geo_columns = '0;

    t_hit_item   hits_to_send[$];
    t_pad_result pads_expected[$];
    int          idle_pct = 0;
    int          mismatch_count = 0;
    int          stall_cycles = 0;

    detector_pad_locator_core #(
        .MAX_ROWS    (MAX_ROWS),
        .COORD_WIDTH (COORD_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pos_row_axis (i_pos_row_axis),
        .i_pos_col_axis (i_pos_col_axis),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_hit_found    (o_hit_found),
        .o_row_index    (o_row_index),
        .o_column_index (o_column_index),
        .o_pad_number   (o_pad_number)
    );

    always #10 i_clk = ~i_clk;

    function automatic int active_rows();
        return (geo_rows > MAX_ROWS) ? MAX_ROWS : int'(geo_rows);
    endfunction

    function automatic t_pad_result locate_pad(logic [COORD_WIDTH-1:0] row_pos,
                                               logic [COORD_WIDTH-1:0] col_pos);
        longint      pr;
        longint      pc;
        longint      lo;
        longint      span;
        int          row;
        int          col;
        int          ncols;
        int          pad;
        t_pad_result res;
        pr  = longint'($signed(row_pos));
        pc  = longint'($signed(col_pos));
        row = 0;
        col = 0;
        pad = 0;
        lo  = longint'(geo_row_org) * 16;
        for (int i = 0; i < active_rows(); i++) begin
            span = longint'(geo_heights[8*i +: 8]) * 16;
            if (row == 0) begin
                if (pr > lo && pr < lo + span) row = i + 1;
                lo += span;
            end
        end
        if (row != 0) begin
            ncols = int'(geo_columns[8*(row-1) +: 8]);
            span  = longint'(geo_widths[8*(row-1) +: 8]) * 16;
            lo    = longint'(geo_col_org) * 16;
            for (int i = 0; i < ncols; i++) begin
                if (col == 0) begin
                    if (pc > lo && pc < lo + span) col = i + 1;
                    lo += span;
                end
            end
            if (col != 0) begin
                for (int i = 0; i + 1 < row; i++) pad += int'(geo_columns[8*i +: 8]);
                pad += col;
            end
        end
        res.hit = (col != 0);
        res.row = row[dpl_pkg::ROW_IDX_W-1:0];
        res.col = col[dpl_pkg::COL_IDX_W-1:0];
        res.pad = pad[dpl_pkg::PAD_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input int want, input int got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
        mismatch_count++;
    endtask

    // driver: hold start until accepted, then advance to the next item
    always @(posedge i_clk) begin
        t_hit_item item;
        logic      taken;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) pads_expected.push_back(locate_pad(i_pos_row_axis, i_pos_col_axis));
            if (!start || taken) begin
                if (hits_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    item = hits_to_send.pop_front();
                    start          <= 1'b1;
                    i_pos_row_axis <= item.row_pos;
                    i_pos_col_axis <= item.col_pos;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pad_result want;
        if (i_rst_n && o_valid) begin
            if (pads_expected.size() == 0) begin
                flag_mismatch("pad_number with no item pending", 0, int'(o_pad_number));
            end else begin
                want = pads_expected.pop_front();
                if (o_hit_found !== want.hit)
                    flag_mismatch("hit_found", int'(want.hit), int'(o_hit_found));
                if (o_row_index !== want.row)
                    flag_mismatch("row_index", int'(want.row), int'(o_row_index));
                if (o_column_index !== want.col)
                    flag_mismatch("column_index", int'(want.col), int'(o_column_index));
                if (o_pad_number !== want.pad)
                    flag_mismatch("pad_number", int'(want.pad), int'(o_pad_number));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_hit(input int row_pos, input int col_pos);
        t_hit_item item;
        item.row_pos = row_pos[COORD_WIDTH-1:0];
        item.col_pos = col_pos[COORD_WIDTH-1:0];
        hits_to_send.push_back(item);
    endtask

    task automatic wait_idle();
        while (hits_to_send.size() > 0 || start || busy || pads_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dpl_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [dpl_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        case (idx)
            dpl_pkg::CFG_COL_ORIGIN:  geo_col_org = data[dpl_pkg::ORG_W-1:0];
            dpl_pkg::CFG_ROW_ORIGIN:  geo_row_org = data[dpl_pkg::ORG_W-1:0];
            dpl_pkg::CFG_ROWS_IN_USE: geo_rows    = data[dpl_pkg::ROWS_W-1:0];
            dpl_pkg::CFG_ROW_HEIGHTS: geo_heights = data;
            dpl_pkg::CFG_ROW_WIDTHS:  geo_widths  = data;
            dpl_pkg::CFG_ROW_COLUMNS: geo_columns = data;
            default: ;
        endcase
    endtask

    task automatic release_cfg_port();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return 8'd0;
        if (roll < 14) return 8'd255;
        return 8'($urandom_range(1, 24));
    endfunction

    function automatic logic [dpl_pkg::CFG_DATA_W-1:0] with_noise(input int value,
                                                                 input int bits);
        logic [dpl_pkg::CFG_DATA_W-1:0] data;
        data = $urandom_range(1) ? {$urandom, $urandom} : '0;
        for (int i = 0; i < bits; i++) data[i] = value[i];
        return data;
    endfunction

    task automatic load_geometry(input int kind);
        logic [dpl_pkg::CFG_DATA_W-1:0] sizes[3];
        int                             org[2];
        int                             rows;
        int                             roll;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 8; i++) begin
                if (kind == GEO_LOWEST) sizes[k][8*i +: 8] = 8'd1;
                else if (kind == GEO_HIGHEST) sizes[k][8*i +: 8] = 8'd255;
                else sizes[k][8*i +: 8] = pick_size();
            end
        end
        for (int k = 0; k < 2; k++) begin
            if (kind == GEO_LOWEST) org[k] = -2048;
            else if (kind == GEO_HIGHEST) org[k] = 2047;
            else if ($urandom_range(99) < 10) org[k] = int'($urandom_range(0, 4095));
            else org[k] = int'($urandom_range(0, 400)) - 200;
        end
        roll = $urandom_range(99);
        if (kind != GEO_RANDOM) rows = 8;
        else if (roll < 8) rows = 0;
        else if (roll < 16) rows = int'($urandom_range(9, 15));
        else rows = int'($urandom_range(1, 8));
        write_reg(dpl_pkg::CFG_COL_ORIGIN, with_noise(org[0], dpl_pkg::ORG_W));
        write_reg(dpl_pkg::CFG_ROW_ORIGIN, with_noise(org[1], dpl_pkg::ORG_W));
        write_reg(dpl_pkg::CFG_ROWS_IN_USE, with_noise(rows, dpl_pkg::ROWS_W));
        write_reg(dpl_pkg::CFG_ROW_HEIGHTS, sizes[0]);
        write_reg(dpl_pkg::CFG_ROW_WIDTHS, sizes[1]);
        write_reg(dpl_pkg::CFG_ROW_COLUMNS, sizes[2]);
        if ($urandom_range(3) == 0) write_reg(CFG_SPARE_7, {$urandom, $urandom});
        release_cfg_port();
    endtask

    // aim most hits at a row and a column slot, edges included
    task automatic queue_aimed_hits(input int count);
        longint lo;
        longint span;
        longint cpos;
        int     r;
        int     c;
        int     ncols;
        for (int k = 0; k < count; k++) begin
            if (active_rows() == 0 || $urandom_range(99) < 15) begin
                queue_hit($urandom, $urandom);
            end else begin
                r  = int'($urandom_range(0, active_rows() - 1));
                lo = longint'(geo_row_org) * 16;
                for (int i = 0; i < r; i++) lo += longint'(geo_heights[8*i +: 8]) * 16;
                span  = longint'(geo_heights[8*r +: 8]) * 16;
                lo   += longint'($urandom_range(0, int'(span)));
                ncols = int'(geo_columns[8*r +: 8]);
                c     = int'($urandom_range(0, ncols));
                span  = longint'(geo_widths[8*r +: 8]) * 16;
                cpos  = longint'(geo_col_org) * 16 + longint'(c) * span
                        + longint'($urandom_range(0, int'(span)));
                queue_hit(int'(lo), int'(cpos));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: one row of zero height, nothing can be found
        queue_hit(-32768, -32768);
        queue_hit(32767, 32767);
        queue_hit(0, 0);
        queue_hit(-472, -1432);
        wait_idle();

        // three rows: heights 2, 3, 4; widths 1, 2, 0; columns 4, 5, 3
        write_reg(dpl_pkg::CFG_COL_ORIGIN, 64'd0);
        write_reg(dpl_pkg::CFG_ROW_ORIGIN, 64'd0);
        write_reg(dpl_pkg::CFG_ROWS_IN_USE, 64'd3);
        write_reg(dpl_pkg::CFG_ROW_HEIGHTS, 64'h0000_0000_0004_0302);
        write_reg(dpl_pkg::CFG_ROW_WIDTHS, 64'h0000_0000_0000_0201);
        write_reg(dpl_pkg::CFG_ROW_COLUMNS, 64'h0000_0000_0003_0504);
        release_cfg_port();
        queue_hit(16, 8);
        queue_hit(16, 56);
        queue_hit(16, 72);
        queue_hit(16, 16);
        queue_hit(32, 8);
        queue_hit(0, 8);
        queue_hit(40, 40);
        queue_hit(90, 10);
        queue_hit(150, 8);
        queue_hit(-5, 8);
        wait_idle();

        write_reg(dpl_pkg::CFG_ROWS_IN_USE, 64'd0);
        release_cfg_port();
        queue_hit(16, 8);
        wait_idle();

        // row count above the limit, unit rows and widths, full columns
        write_reg(dpl_pkg::CFG_COL_ORIGIN, 64'hFFFF_FFFF_FFFF_F800);
        write_reg(dpl_pkg::CFG_ROW_ORIGIN, 64'h0000_0000_0000_0800);
        write_reg(dpl_pkg::CFG_ROWS_IN_USE, 64'hA5A5_0000_0000_000D);
        write_reg(dpl_pkg::CFG_ROW_HEIGHTS, 64'h0101_0101_0101_0101);
        write_reg(dpl_pkg::CFG_ROW_WIDTHS, 64'h0101_0101_0101_0101);
        write_reg(dpl_pkg::CFG_ROW_COLUMNS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SPARE_7, 64'h0);
        release_cfg_port();
        queue_hit(-32648, -28696);
        queue_hit(-32648, -32760);
        queue_hit(-32760, -32760);
        queue_hit(-32632, -32760);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) load_geometry(GEO_LOWEST);
            else if (p == 1) load_geometry(GEO_HIGHEST);
            else load_geometry(GEO_RANDOM);
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 74;
                default: idle_pct = 26;
            endcase
            queue_aimed_hits(PHASE_HITS);
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dpl_pkg.sv
sv/dpl_cfg.sv
sv/dpl_sub.sv
sv/dpl_seq.sv
sv/detector_pad_locator_core.sv
sim/tb_detector_pad_locator_core.sv
